// ===== sv/vad_pkg.sv =====
// ============================================================================
// vad_pkg
// Constants and the sine table builder shared by the angle pipeline.
// ============================================================================
package vad_pkg;

    localparam int ANGLE_STEPS = 7;
    localparam int TABLE_LEN   = 91;
    localparam int TABLE_SLOTS = 128;
    localparam int DEG_W       = 7;
    localparam int ANGLE_OUT_W = 10;
    localparam int ANGLE_W     = 11;
    localparam int DEG_90      = 90;
    localparam int DEG_180     = 180;
    localparam int DEG_360     = 360;
    localparam int HYP_FRAC    = 8;

    // sin(d degrees) in millionths, d = 0..90
    localparam int unsigned SINE_MICRO [0:TABLE_LEN-1] = '{
        0, 17452, 34899, 52336, 69756, 87156, 104528, 121869,
        139173, 156434, 173648, 190809, 207912, 224951, 241922, 258819,
        275637, 292372, 309017, 325568, 342020, 358368, 374607, 390731,
        406737, 422618, 438371, 453990, 469472, 484810, 500000, 515038,
        529919, 544639, 559193, 573576, 587785, 601815, 615661, 629320,
        642788, 656059, 669131, 681998, 694658, 707107, 719340, 731354,
        743145, 754710, 766044, 777146, 788011, 798636, 809017, 819152,
        829038, 838671, 848048, 857167, 866025, 874620, 882948, 891007,
        898794, 906308, 913545, 920505, 927184, 933580, 939693, 945519,
        951057, 956305, 961262, 965926, 970296, 974370, 978148, 981627,
        984808, 987688, 990268, 992546, 994522, 996195, 997564, 998630,
        999391, 999848, 1000000
    };

    localparam longint unsigned MICRO_ONE  = 64'd1000000;
    localparam longint unsigned MICRO_HALF = 64'd500000;

    // table entry rounded to the given fraction width; evaluated at elaboration
    function automatic longint unsigned sine_q(input int deg, input int frac);
        longint unsigned m;
        m = longint'(SINE_MICRO[deg]);
        return ((m << frac) + MICRO_HALF) / MICRO_ONE;
    endfunction

endpackage

// ===== sv/vad_point_if.sv =====
// ============================================================================
// vad_point_if
// Input channel: one transaction carries a pair of points.
// ============================================================================
interface vad_point_if #(
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;

    modport source (output valid, output first_x, output first_y,
                    output second_x, output second_y, input ready);
    modport sink   (input valid, input first_x, input first_y,
                    input second_x, input second_y, output ready);
endinterface

// ===== sv/vad_angle_if.sv =====
// ============================================================================
// vad_angle_if
// Output channel: one transaction carries one rotation angle.
// ============================================================================
interface vad_angle_if;
    logic                                valid;
    logic                                ready;
    logic signed [vad_pkg::ANGLE_OUT_W-1:0] rotation_degrees;

    modport source (output valid, output rotation_degrees, input ready);
    modport sink   (input valid, input rotation_degrees, output ready);
endinterface

// ===== sv/vad_sqrt.sv =====
// ============================================================================
// vad_sqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module vad_sqrt #(
    parameter int IN_W   = 50,
    parameter int SIDE_W = 19
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_value,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);
    localparam int R  = IN_W / 2;
    localparam int RW = R + 3;

    logic              val_reg  [0:R-1];
    logic [IN_W-1:0]   w_reg    [0:R-1];
    logic [RW-1:0]     rem_reg  [0:R-1];
    logic [R-1:0]      root_reg [0:R-1];
    logic [SIDE_W-1:0] side_reg [0:R-1];

    for (genvar k = 0; k < R; k++) begin : g_stage
        logic              val_prev;
        logic [IN_W-1:0]   w_prev;
        logic [RW-1:0]     rem_prev;
        logic [R-1:0]      root_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [RW-1:0]     rem_sh;
        logic [RW-1:0]     trial;
        logic [RW-1:0]     rem_next;
        logic [R-1:0]      root_next;

        if (k == 0) begin : g_first
            assign val_prev  = in_valid;
            assign w_prev    = in_value;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
        end else begin : g_rest
            assign val_prev  = val_reg[k-1];
            assign w_prev    = w_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign rem_sh = {rem_prev[RW-3:0], w_prev[IN_W-1 -: 2]};
        assign trial  = {1'b0, root_prev, 2'b01};

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_prev[R-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_prev[R-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[k] <= val_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                w_reg[k]    <= {w_prev[IN_W-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = val_reg[R-1];
    assign out_root  = root_reg[R-1];
    assign out_side  = side_reg[R-1];

endmodule

// ===== sv/vad_div.sv =====
// ============================================================================
// vad_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must already be below the divisor.
// ============================================================================
module vad_div #(
    parameter int D_W    = 25,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [D_W-1:0]    in_rem,
    input  logic [D_W-1:0]    in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);
    logic              val_reg  [0:Q_W-1];
    logic [D_W-1:0]    rem_reg  [0:Q_W-1];
    logic [D_W-1:0]    den_reg  [0:Q_W-1];
    logic [Q_W-1:0]    quot_reg [0:Q_W-1];
    logic [SIDE_W-1:0] side_reg [0:Q_W-1];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic              val_prev;
        logic [D_W-1:0]    rem_prev;
        logic [D_W-1:0]    den_prev;
        logic [Q_W-1:0]    quot_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [D_W:0]      rem_sh;
        logic [D_W:0]      diff;

        if (k == 0) begin : g_first
            assign val_prev  = in_valid;
            assign rem_prev  = in_rem;
            assign den_prev  = in_den;
            assign quot_prev = '0;
            assign side_prev = in_side;
        end else begin : g_rest
            assign val_prev  = val_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign quot_prev = quot_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign rem_sh = {rem_prev, 1'b0};
        assign diff   = rem_sh - {1'b0, den_prev};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[k] <= val_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= {1'b0, den_prev})
                begin
                    rem_reg[k]  <= diff[D_W-1:0];
                    quot_reg[k] <= {quot_prev[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh[D_W-1:0];
                    quot_reg[k] <= {quot_prev[Q_W-2:0], 1'b0};
                end
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = val_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== sv/vector_angle_degrees.sv =====
// ============================================================================
// vector_angle_degrees
// Direction of the vector between two points, in whole degrees minus 90.
// ============================================================================
// Channel req (sink) takes one point pair per transaction; channel rsp
// (source) returns the angle. A pair whose points coincide gives no
// transaction on rsp. All other pairs give exactly one, in input order.
// Results pass through the difference, square and sum registers, the
// square root (COORD_BITS + 9 root bits), the divider (SINE_FRAC_BITS + 1
// quotient bits), 7 table search steps and the output register.
// One transaction is taken every cycle while rsp is free or being drained.
// When rsp.ready is low and a result is held, the whole pipeline freezes
// and req.ready drops; nothing is lost or repeated.
// Reset clears all valid bits; req.ready is high as soon as reset is released.
// ============================================================================
module vector_angle_degrees #(
    parameter int COORD_BITS     = 16,
    parameter int SINE_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    vad_point_if.sink           req,
    vad_angle_if.source         rsp
);
    localparam int C    = COORD_BITS;
    localparam int F    = SINE_FRAC_BITS;
    localparam int DW   = C + 1;
    localparam int SQW  = 2 * C + 2;
    localparam int SW   = 2 * C + 18;
    localparam int R    = SW / 2;
    localparam int QW   = F + 1;
    localparam int DG   = vad_pkg::DEG_W;
    localparam int AW   = vad_pkg::ANGLE_W;
    localparam int STEPS = vad_pkg::ANGLE_STEPS;

    logic adv;
    logic out_valid_reg;
    logic signed [vad_pkg::ANGLE_OUT_W-1:0] out_angle_reg;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    // sine table at Q(F)
    logic [QW-1:0] sine_tab [0:vad_pkg::TABLE_SLOTS-1];
    for (genvar g = 0; g < vad_pkg::TABLE_SLOTS; g++) begin : g_tab
        if (g < vad_pkg::TABLE_LEN) begin : g_used
            assign sine_tab[g] = QW'(vad_pkg::sine_q(g, F));
        end else begin : g_unused
            assign sine_tab[g] = '0;
        end
    end

    // stage A: differences
    logic signed [DW-1:0] dx_c, dy_c;
    logic                 a_valid_reg;
    logic signed [DW-1:0] a_dx_reg, a_dy_reg;

    assign dx_c = $signed({req.second_x[C-1], req.second_x})
                - $signed({req.first_x[C-1], req.first_x});
    assign dy_c = $signed({req.second_y[C-1], req.second_y})
                - $signed({req.first_y[C-1], req.first_y});

    // stage B: magnitudes and squares
    logic [DW-1:0]  ax_c, ay_c;
    logic           b_valid_reg;
    logic [SQW-1:0] b_sqx_reg, b_sqy_reg;
    logic [DW-1:0]  b_ay_reg;
    logic           b_dxn_reg, b_dyn_reg;

    assign ax_c = a_dx_reg[DW-1] ? DW'(-a_dx_reg) : DW'(a_dx_reg);
    assign ay_c = a_dy_reg[DW-1] ? DW'(-a_dy_reg) : DW'(a_dy_reg);

    // stage C: sum of squares
    logic           c_valid_reg;
    logic [SQW-1:0] c_sum_reg;
    logic [DW-1:0]  c_ay_reg;
    logic           c_dxn_reg, c_dyn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= req.valid && !(dx_c == '0 && dy_c == '0);
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg  <= dx_c;
            a_dy_reg  <= dy_c;
            b_sqx_reg <= SQW'(ax_c) * SQW'(ax_c);
            b_sqy_reg <= SQW'(ay_c) * SQW'(ay_c);
            b_ay_reg  <= ay_c;
            b_dxn_reg <= a_dx_reg[DW-1];
            b_dyn_reg <= a_dy_reg[DW-1];
            c_sum_reg <= b_sqx_reg + b_sqy_reg;
            c_ay_reg  <= b_ay_reg;
            c_dxn_reg <= b_dxn_reg;
            c_dyn_reg <= b_dyn_reg;
        end
    end

    // hypotenuse in Q8
    logic          s_valid;
    logic [R-1:0]  s_hyp;
    logic [DW+1:0] s_side;

    vad_sqrt #(
        .IN_W   (SW),
        .SIDE_W (DW + 2)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c_valid_reg),
        .in_value  ({c_sum_reg, 16'd0}),
        .in_side   ({c_ay_reg, c_dxn_reg, c_dyn_reg}),
        .out_valid (s_valid),
        .out_root  (s_hyp),
        .out_side  (s_side)
    );

    // sine = (ay << (8+F)) / hyp; upper quotient bits are known zero
    logic          q_valid;
    logic [QW-1:0] q_sine;
    logic [1:0]    q_side;

    vad_div #(
        .D_W    (R),
        .Q_W    (QW),
        .SIDE_W (2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_valid),
        .in_rem    (R'({s_side[DW+1:2], 7'd0})),
        .in_den    (s_hyp),
        .in_side   (s_side[1:0]),
        .out_valid (q_valid),
        .out_quot  (q_sine),
        .out_side  (q_side)
    );

    // halving search over the table
    logic          t_valid_reg [0:STEPS-1];
    logic [DG-1:0] t_lo_reg    [0:STEPS-1];
    logic [DG-1:0] t_hi_reg    [0:STEPS-1];
    logic [QW-1:0] t_sine_reg  [0:STEPS-1];
    logic [1:0]    t_side_reg  [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_search
        logic          val_prev;
        logic [DG-1:0] lo_prev, hi_prev;
        logic [QW-1:0] sine_prev;
        logic [1:0]    side_prev;
        logic [DG:0]   mid_sum;
        logic [DG-1:0] mid;

        if (k == 0) begin : g_first
            assign val_prev  = q_valid;
            assign lo_prev   = '0;
            assign hi_prev   = DG'(vad_pkg::DEG_90);
            assign sine_prev = q_sine;
            assign side_prev = q_side;
        end else begin : g_rest
            assign val_prev  = t_valid_reg[k-1];
            assign lo_prev   = t_lo_reg[k-1];
            assign hi_prev   = t_hi_reg[k-1];
            assign sine_prev = t_sine_reg[k-1];
            assign side_prev = t_side_reg[k-1];
        end

        assign mid_sum = {1'b0, lo_prev} + {1'b0, hi_prev};
        assign mid     = mid_sum[DG:1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                t_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                t_valid_reg[k] <= val_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sine_tab[mid] < sine_prev)
                begin
                    t_lo_reg[k] <= mid;
                    t_hi_reg[k] <= hi_prev;
                end
                else
                begin
                    t_lo_reg[k] <= lo_prev;
                    t_hi_reg[k] <= mid;
                end
                t_sine_reg[k] <= sine_prev;
                t_side_reg[k] <= side_prev;
            end
        end
    end

    // nearer bracket, quadrant fold, offset
    logic [QW-1:0]       f_sine, f_tlo, f_thi, d_lo, d_hi;
    logic [DG-1:0]       f_r;
    logic                f_dxn, f_dyn;
    logic signed [AW-1:0] f_angle, f_out;

    assign f_sine = t_sine_reg[STEPS-1];
    assign f_tlo  = sine_tab[t_lo_reg[STEPS-1]];
    assign f_thi  = sine_tab[t_hi_reg[STEPS-1]];
    assign d_lo   = (f_tlo > f_sine) ? f_tlo - f_sine : f_sine - f_tlo;
    assign d_hi   = (f_thi > f_sine) ? f_thi - f_sine : f_sine - f_thi;
    assign f_r    = (d_lo < d_hi) ? t_lo_reg[STEPS-1] : t_hi_reg[STEPS-1];
    assign f_dxn  = t_side_reg[STEPS-1][1];
    assign f_dyn  = t_side_reg[STEPS-1][0];

    always_comb
    begin
        case ({f_dxn, f_dyn})
            2'b10:   f_angle = AW'(vad_pkg::DEG_180) - AW'(f_r);
            2'b11:   f_angle = AW'(vad_pkg::DEG_180) + AW'(f_r);
            2'b01:   f_angle = AW'(vad_pkg::DEG_360) - AW'(f_r);
            default: f_angle = AW'(f_r);
        endcase
    end

    assign f_out = f_angle - AW'(vad_pkg::DEG_90);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= t_valid_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_angle_reg <= f_out[vad_pkg::ANGLE_OUT_W-1:0];
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.rotation_degrees = out_angle_reg;

endmodule

// ===== sim/vector_angle_degrees_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vector_angle_degrees_test
// Drives point pairs into the angle pipeline and checks each angle against
// an in-bench predictor, with random idling on both channels.
// ============================================================================
module vector_angle_degrees_test;

    localparam int COORD_BITS     = 16;
    localparam int SINE_FRAC_BITS = 16;
    localparam int LATENCY        = COORD_BITS + SINE_FRAC_BITS + 21;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    vad_point_if #(.COORD_BITS(COORD_BITS)) req ();
    vad_angle_if rsp ();

    vector_angle_degrees #(
        .COORD_BITS    (COORD_BITS),
        .SINE_FRAC_BITS(SINE_FRAC_BITS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    always #4 clk = ~clk;

    logic signed [vad_pkg::ANGLE_OUT_W-1:0] angle_queue[$];
    longint unsigned                        sine_lut[0:vad_pkg::TABLE_LEN-1];
    idle_mode_t                             idle_mode = IDLE_NONE;
    int                                     stall_hold = 0;
    int                                     error_count = 0;
    int                                     quiet_cycles = 0;

    // sine table in Q16, halves rounding up
    initial
    begin
        for (int d = 0; d < vad_pkg::TABLE_LEN; d++)
            sine_lut[d] = ((longint'(vad_pkg::SINE_MICRO[d]) << SINE_FRAC_BITS) + 500000)
                          / 1000000;
    end

    function automatic longint unsigned hypot_q8(input longint unsigned v);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned pair;
        longint unsigned trial;
        root = 0;
        rem = 0;
        for (int i = 0; i < 40; i++)
        begin
            pair = (i < 32) ? ((v >> (62 - 2 * i)) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    // returns 0 when the points coincide
    function automatic bit predict_angle(input logic signed [15:0] x1, input logic signed [15:0] y1,
                                         input logic signed [15:0] x2, input logic signed [15:0] y2,
                                         output logic signed [vad_pkg::ANGLE_OUT_W-1:0] angle);
        longint          dx;
        longint          dy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned hyp;
        longint unsigned sine;
        longint unsigned dlo;
        longint unsigned dhi;
        int              lo;
        int              hi;
        int              mid;
        int              r;
        int              deg;
        dx = longint'(x2) - longint'(x1);
        dy = longint'(y2) - longint'(y1);
        angle = '0;
        if (dx == 0 && dy == 0)
            return 1'b0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        hyp = hypot_q8(ax * ax + ay * ay);
        sine = (hyp != 0) ? (ay << (vad_pkg::HYP_FRAC + SINE_FRAC_BITS)) / hyp : 0;
        lo = 0;
        hi = vad_pkg::DEG_90;
        for (int k = 0; k < vad_pkg::ANGLE_STEPS; k++)
        begin
            mid = lo + (hi - lo) / 2;
            if (sine_lut[mid] < sine)
                lo = mid;
            else
                hi = mid;
        end
        dlo = (sine_lut[lo] > sine) ? sine_lut[lo] - sine : sine - sine_lut[lo];
        dhi = (sine_lut[hi] > sine) ? sine_lut[hi] - sine : sine - sine_lut[hi];
        r = (dlo < dhi) ? lo : hi;
        deg = r;
        if (dx < 0 && dy >= 0)
            deg = vad_pkg::DEG_180 - r;
        else if (dx < 0 && dy < 0)
            deg = vad_pkg::DEG_180 + r;
        else if (dx >= 0 && dy < 0)
            deg = vad_pkg::DEG_360 - r;
        angle = vad_pkg::ANGLE_OUT_W'(deg - vad_pkg::DEG_90);
        return 1'b1;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // valid stays high after the transaction until the next call or the drain
    task automatic send_points(input logic [15:0] x1, input logic [15:0] y1,
                               input logic [15:0] x2, input logic [15:0] y2);
        logic signed [vad_pkg::ANGLE_OUT_W-1:0] angle;
        while ((idle_mode == IDLE_SENDER && roll(46)) || (idle_mode == IDLE_BOTH && roll(6)))
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.first_x  <= x1;
        req.first_y  <= y1;
        req.second_x <= x2;
        req.second_y <= y2;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (predict_angle(x1, y1, x2, y2, angle))
            angle_queue.push_back(angle);
        @(negedge clk);
    endtask

    task automatic send_random(input int count, input int span);
        logic [15:0] x1;
        logic [15:0] y1;
        for (int i = 0; i < count; i++)
        begin
            x1 = 16'($urandom);
            y1 = 16'($urandom);
            if (span == 0 || roll(20))
                send_points(x1, y1, 16'($urandom), 16'($urandom));
            else
                send_points(x1, y1, 16'(x1 + $urandom_range(2 * span, 0) - span),
                            16'(y1 + $urandom_range(2 * span, 0) - span));
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (angle_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic test_directed();
        idle_mode = IDLE_NONE;
        send_points(16'h0000, 16'h0000, 16'h0000, 16'h0000);   // same point
        send_points(16'h1234, 16'h8000, 16'h1234, 16'h8000);   // same point, extremes
        send_points(16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_points(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        send_points(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        send_points(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_points(16'h0000, 16'h0000, 16'h0001, 16'h0001);
        send_points(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_points(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);   // largest differences
        send_points(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_points(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_points(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        // tiny downward angle folds to 360
        send_points(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF);
        send_points(16'h8000, 16'h0001, 16'h7FFF, 16'h0000);
        send_points(16'h0000, 16'h0000, 16'h8000, 16'hFFFF);
        send_points(16'h0000, 16'h0000, 16'h7FFF, 16'h0001);
        send_points(16'h0000, 16'h0000, 16'h0003, 16'h0004);
        send_points(16'h0000, 16'h0000, 16'hFFFD, 16'hFFFC);
        send_points(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        wait_drained();
    endtask

    task automatic test_idling(input idle_mode_t mode, input int count);
        idle_mode = mode;
        send_random(count / 2, 0);
        send_random(count / 2, 40);
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        stall_hold = 3 * LATENCY;
        send_random(150, 8);
        wait_drained();
    endtask

    // receiver
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            rsp.ready <= 1'b0;
            stall_hold <= stall_hold - 1;
        end
        else if (idle_mode == IDLE_RECEIVER)
            rsp.ready <= !roll(46);
        else if (idle_mode == IDLE_BOTH)
            rsp.ready <= !roll(6);
        else
            rsp.ready <= 1'b1;
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (angle_queue.size() == 0)
                begin
                    $error("unexpected transaction: rotation_degrees actual %0d",
                           rsp.rotation_degrees);
                    error_count <= error_count + 1;
                end
                else
                begin
                    if (rsp.rotation_degrees !== angle_queue[0])
                    begin
                        $error("rotation_degrees mismatch: expected %0d actual %0d",
                               angle_queue[0], rsp.rotation_degrees);
                        error_count <= error_count + 1;
                    end
                    void'(angle_queue.pop_front());
                end
            end
        end
    end

    initial
    begin
        req.valid    = 1'b0;
        req.first_x  = '0;
        req.first_y  = '0;
        req.second_x = '0;
        req.second_y = '0;
        rsp.ready    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_idling(IDLE_NONE, 340);
        test_idling(IDLE_SENDER, 320);
        test_idling(IDLE_RECEIVER, 320);
        test_idling(IDLE_BOTH, 300);
        test_backpressure();
        if (error_count == 0 && angle_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
sv/vad_pkg.sv
sv/vad_point_if.sv
sv/vad_angle_if.sv
sv/vad_sqrt.sv
sv/vad_div.sv
sv/vector_angle_degrees.sv
sim/vector_angle_degrees_test.sv
